@@ src/bbdr_pkg.sv @@
// ----------------------------------------------------------------------------
// bbdr_pkg
// Shared types and constants for the beam-break debounce reporter.
// ----------------------------------------------------------------------------
package bbdr_pkg;

  localparam int TIMER_BITS = 24;
  localparam int COUNT_BITS = 32;
  localparam int DEB_W      = 16;
  localparam int GAP_W      = 16;
  localparam int HB_W       = 24;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CMP_W      = (TIMER_BITS > HB_W) ? TIMER_BITS : HB_W;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = CFG_IDX_W'(3);

  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(50);
  localparam logic [GAP_W-1:0] MIN_GAP_RST   = GAP_W'(500);
  localparam logic [HB_W-1:0]  HEARTBEAT_RST = HB_W'(30000);

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_STATE = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  // event slots in emit order
  localparam int EV_LINK  = 0;
  localparam int EV_CONF  = 1;
  localparam int EV_COUNT = 2;
  localparam int EV_HB    = 3;
  localparam int EV_N     = 4;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [GAP_W-1:0] min_gap_ticks;
    logic [HB_W-1:0]  heartbeat_ticks;
    logic             active_high;
  } cfg_t;

  // everything one tick produces
  typedef struct packed {
    logic [EV_N-1:0]       pend;
    logic                  old_conf;
    logic                  new_conf;
    logic [TOTAL_W-1:0]    old_total;
    logic [TOTAL_W-1:0]    new_total;
  } bundle_t;

endpackage

@@ src/bbdr_if.sv @@
// ----------------------------------------------------------------------------
// bbdr_if
// Valid/ready channel interfaces for ticks, reports and config writes.
// ----------------------------------------------------------------------------
interface bbdr_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic link_up;
  modport source (output valid, output pin_level, output link_up, input ready);
  modport sink   (input valid, input pin_level, input link_up, output ready);
endinterface

interface bbdr_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic                           beam_blocked;
  logic [bbdr_pkg::TOTAL_W-1:0]   blocked_total;
  logic                           last;
  modport source (output valid, output kind, output beam_blocked,
                  output blocked_total, output last, input ready);
  modport sink   (input valid, input kind, input beam_blocked,
                  input blocked_total, input last, output ready);
endinterface

interface bbdr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bbdr_pkg::CFG_IDX_W-1:0]    index;
  logic [bbdr_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/bbdr_step.sv @@
// ----------------------------------------------------------------------------
// bbdr_step
// Debounce / rate-limit state and the single-pass per-tick update.
// ----------------------------------------------------------------------------
module bbdr_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             pin,
  input  logic             link,
  input  bbdr_pkg::cfg_t   cfg,
  output bbdr_pkg::bundle_t bundle
);
  import bbdr_pkg::*;

  logic                  started_r, raw_r, conf_r, link_was_r;
  logic [TIMER_BITS-1:0] s_raw_r, s_blk_r, s_clr_r, s_hb_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic                  started_nxt, raw_nxt, conf_nxt;
  logic [TIMER_BITS-1:0] s_raw_nxt, s_blk_nxt, s_clr_nxt, s_hb_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;

  logic                  blocked_now, conf1, link_ev, conf_ev, cnt_ev, hb_ev;
  logic [TIMER_BITS-1:0] gap;

  function automatic logic [TIMER_BITS-1:0] adv(input logic [TIMER_BITS-1:0] t);
    adv = (t == TIMER_MAX) ? TIMER_MAX : t + TIMER_BITS'(1);
  endfunction

  always_comb begin
    blocked_now = cfg.active_high ? pin : ~pin;
    started_nxt = 1'b1;
    raw_nxt     = raw_r;
    conf_nxt    = conf_r;
    s_raw_nxt   = s_raw_r;
    s_blk_nxt   = s_blk_r;
    s_clr_nxt   = s_clr_r;
    s_hb_nxt    = s_hb_r;
    cnt_nxt     = cnt_r;

    if (!started_r) begin
      raw_nxt  = blocked_now;
      conf_nxt = blocked_now;
      s_hb_nxt = '0;
    end else begin
      s_raw_nxt = adv(s_raw_r);
      s_blk_nxt = adv(s_blk_r);
      s_clr_nxt = adv(s_clr_r);
      s_hb_nxt  = adv(s_hb_r);
    end
    conf1 = conf_nxt;

    link_ev = link & ~link_was_r;
    if (link_ev) s_hb_nxt = '0;

    if (blocked_now != raw_nxt) begin
      raw_nxt   = blocked_now;
      s_raw_nxt = '0;
    end

    gap     = raw_nxt ? s_blk_nxt : s_clr_nxt;
    conf_ev = (raw_nxt != conf_nxt)
              && (CMP_W'(s_raw_nxt) >= CMP_W'(cfg.debounce_ticks))
              && (CMP_W'(gap) >= CMP_W'(cfg.min_gap_ticks));
    cnt_ev  = conf_ev & raw_nxt;
    if (conf_ev) begin
      conf_nxt = raw_nxt;
      if (raw_nxt) s_blk_nxt = '0;
      else         s_clr_nxt = '0;
      s_hb_nxt = '0;
    end
    if (cnt_ev) cnt_nxt = cnt_r + COUNT_BITS'(1);

    hb_ev = CMP_W'(s_hb_nxt) >= CMP_W'(cfg.heartbeat_ticks);
    if (hb_ev) s_hb_nxt = '0;

    bundle.pend[EV_LINK]  = link_ev;
    bundle.pend[EV_CONF]  = conf_ev;
    bundle.pend[EV_COUNT] = cnt_ev;
    bundle.pend[EV_HB]    = hb_ev;
    bundle.old_conf       = conf1;
    bundle.new_conf       = conf_nxt;
    bundle.old_total      = TOTAL_W'(cnt_r);
    bundle.new_total      = TOTAL_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      raw_r      <= 1'b0;
      conf_r     <= 1'b0;
      link_was_r <= 1'b0;
      s_raw_r    <= '0;
      s_blk_r    <= '0;
      s_clr_r    <= '0;
      s_hb_r     <= '0;
      cnt_r      <= '0;
    end else if (fire) begin
      started_r  <= started_nxt;
      raw_r      <= raw_nxt;
      conf_r     <= conf_nxt;
      link_was_r <= link;
      s_raw_r    <= s_raw_nxt;
      s_blk_r    <= s_blk_nxt;
      s_clr_r    <= s_clr_nxt;
      s_hb_r     <= s_hb_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

@@ src/beam_break_debounce_reporter.sv @@
// ----------------------------------------------------------------------------
// beam_break_debounce_reporter
// Debounced, rate-limited beam-break state reporting with heartbeat.
// ----------------------------------------------------------------------------
// A tick moves from the input register through the step logic into the report
// register. Throughput: one tick per cycle while out_ch is ready and each tick
//   yields one report; a tick with n reports (1..4) holds it for n transfers.
// Reset (rst_n, synchronous, active low): state and counters cleared, config
//   back to debounce 50, min gap 500, heartbeat 30000, active low pin.
module beam_break_debounce_reporter (
  input  logic      clk,
  input  logic      rst_n,
  bbdr_in_if.sink   in_ch,
  bbdr_out_if.source out_ch,
  bbdr_cfg_if.sink  cfg_ch
);
  import bbdr_pkg::*;

  // config registers; writes should only land while idle, but the block does not enforce it; always ready
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= DEBOUNCE_RST;
      cfg_r.min_gap_ticks   <= MIN_GAP_RST;
      cfg_r.heartbeat_ticks <= HEARTBEAT_RST;
      cfg_r.active_high     <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE:    cfg_r.debounce_ticks  <= cfg_ch.data[DEB_W-1:0];
        REG_MIN_GAP:     cfg_r.min_gap_ticks   <= cfg_ch.data[GAP_W-1:0];
        REG_HEARTBEAT:   cfg_r.heartbeat_ticks <= cfg_ch.data[HB_W-1:0];
        REG_ACTIVE_HIGH: cfg_r.active_high     <= cfg_ch.data[0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // input register: the tick waiting for the step logic
  logic in_valid_r, in_pin_r, in_link_r;

  // report register: one tick's events, drained one transfer at a time
  logic    b_valid_r;
  bundle_t b_r;
  bundle_t step_out;

  logic            out_fire, is_last, b_free, step_fire;
  logic [EV_N-1:0] low_bit;
  kind_t           kind;
  logic            blk;
  logic [TOTAL_W-1:0] total;

  // pick the earliest pending event; empty mask means a plain status report
  always_comb begin
    low_bit = '0;
    kind    = KIND_NONE;
    blk     = b_r.new_conf;
    total   = b_r.new_total;
    if (b_r.pend[EV_LINK]) begin
      low_bit[EV_LINK] = 1'b1;
      kind  = KIND_STATE;
      blk   = b_r.old_conf;
      total = b_r.old_total;
    end else if (b_r.pend[EV_CONF]) begin
      low_bit[EV_CONF] = 1'b1;
      kind  = KIND_STATE;
      total = b_r.old_total;   // count bumps after the state event
    end else if (b_r.pend[EV_COUNT]) begin
      low_bit[EV_COUNT] = 1'b1;
      kind = KIND_COUNT;
    end else if (b_r.pend[EV_HB]) begin
      low_bit[EV_HB] = 1'b1;
      kind = KIND_STATE;
    end
    is_last = (b_r.pend & ~low_bit) == '0;
  end

  assign out_fire  = b_valid_r & out_ch.ready;
  assign b_free    = ~b_valid_r | (out_fire & is_last);
  assign step_fire = in_valid_r & b_free;
  assign in_ch.ready = ~in_valid_r | step_fire;

  assign out_ch.valid         = b_valid_r;
  assign out_ch.kind          = kind;
  assign out_ch.beam_blocked  = blk;
  assign out_ch.blocked_total = total;
  assign out_ch.last          = is_last;

  bbdr_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (step_fire),
    .pin    (in_pin_r),
    .link   (in_link_r),
    .cfg    (cfg_r),
    .bundle (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (b_free)      b_valid_r  <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_pin_r  <= in_ch.pin_level;
      in_link_r <= in_ch.link_up;
    end
    if (step_fire) begin
      b_r <= step_out;
    end else if (out_fire) begin
      b_r.pend <= b_r.pend & ~low_bit;
    end
  end

endmodule

@@ tb/sv/bbdr_report_sb_pkg.sv @@
// ----------------------------------------------------------------------------
// bbdr_report_sb_pkg
// Report predictor and scoreboard for the beam-break debounce reporter.
// Each accepted tick is run through a cycle-free model of the block. The
// reports it yields are queued, and each report from the block is checked
// against the oldest one.
// ----------------------------------------------------------------------------
package bbdr_report_sb_pkg;
  import bbdr_pkg::*;

  typedef struct {
    kind_t              kind;
    logic               blocked;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } report_t;

  class report_scoreboard;
    report_t               reports_due[$];
    int unsigned           errors;
    cfg_t                  regs;
    logic                  started;
    logic                  raw_blk;
    logic                  conf_blk;
    logic                  link_prev;
    logic [TIMER_BITS-1:0] since_raw;
    logic [TIMER_BITS-1:0] since_blk;
    logic [TIMER_BITS-1:0] since_clr;
    logic [TIMER_BITS-1:0] since_hb;
    logic [COUNT_BITS-1:0] blk_count;

    function new();
      regs = '{debounce_ticks: DEBOUNCE_RST, min_gap_ticks: MIN_GAP_RST,
               heartbeat_ticks: HEARTBEAT_RST, active_high: 1'b0};
      started   = 1'b0;
      raw_blk   = 1'b0;
      conf_blk  = 1'b0;
      link_prev = 1'b0;
      since_raw = '0;
      since_blk = '0;
      since_clr = '0;
      since_hb  = '0;
      blk_count = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:    regs.debounce_ticks  = data[DEB_W-1:0];
        REG_MIN_GAP:     regs.min_gap_ticks   = data[GAP_W-1:0];
        REG_HEARTBEAT:   regs.heartbeat_ticks = data[HB_W-1:0];
        REG_ACTIVE_HIGH: regs.active_high     = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return reports_due.size();
    endfunction

    // saturating elapsed-tick counter
    local function logic [TIMER_BITS-1:0] bump(logic [TIMER_BITS-1:0] t);
      return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

    local function void add_report(kind_t k);
      report_t r;
      r.kind    = k;
      r.blocked = conf_blk;
      r.total   = TOTAL_W'(blk_count);
      r.last    = 1'b0;
      reports_due.push_back(r);
    endfunction

    function void note_tick(logic pin, logic link);
      logic        blk_now;
      int unsigned n_before;
      n_before = reports_due.size();
      blk_now  = regs.active_high ? pin : !pin;

      if (!started) begin
        // first tick loads raw and confirmed state straight from the pin
        started  = 1'b1;
        raw_blk  = blk_now;
        conf_blk = blk_now;
        since_hb = '0;
      end else begin
        since_raw = bump(since_raw);
        since_blk = bump(since_blk);
        since_clr = bump(since_clr);
        since_hb  = bump(since_hb);
      end

      if (link && !link_prev) begin
        since_hb = '0;
        add_report(KIND_STATE);
      end
      link_prev = link;

      if (blk_now != raw_blk) begin
        raw_blk   = blk_now;
        since_raw = '0;
      end

      if (raw_blk != conf_blk && since_raw >= regs.debounce_ticks) begin
        if ((raw_blk ? since_blk : since_clr) >= regs.min_gap_ticks) begin
          conf_blk = raw_blk;
          if (raw_blk) since_blk = '0;
          else         since_clr = '0;
          since_hb = '0;
          add_report(KIND_STATE);
          if (conf_blk) begin
            blk_count = blk_count + 1'b1;
            add_report(KIND_COUNT);
          end
        end
      end

      if (since_hb >= regs.heartbeat_ticks) begin
        since_hb = '0;
        add_report(KIND_STATE);
      end

      if (reports_due.size() == n_before) add_report(KIND_NONE);
      reports_due[reports_due.size()-1].last = 1'b1;
    endfunction

    local function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [1:0] kind, logic blocked,
                               logic [TOTAL_W-1:0] total, logic last);
      report_t w;
      if (reports_due.size() == 0) begin
        $error("report with nothing pending: kind %0d total %0h", kind, total);
        errors++;
        return;
      end
      w = reports_due.pop_front();
      check_field("kind", w.kind, kind);
      check_field("beam_blocked", w.blocked, blocked);
      check_field("blocked_total", w.total, total);
      check_field("last", w.last, last);
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the beam-break debounce reporter.
// Drives ticks through the input channel under random idling
// on both sides, reprograms the registers between phases, and checks every
// report against a predictor: first a short directed sweep (first tick,
// link edges, zero thresholds, debounce and gap hold-off, heartbeat), then
// randomized pin runs across several register settings including extremes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbdr_pkg::*;
  import bbdr_report_sb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;        // set: neither side idles
  report_scoreboard sb;

  bbdr_in_if  in_ch();
  bbdr_out_if out_ch();
  bbdr_cfg_if cfg_ch();

  beam_break_debounce_reporter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tick source. Valid stays high from one transfer into the next when no
  // idle cycle falls between them, so it never gets two updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic pin, input logic link);
    while (!calm && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    in_ch.link_up   <= link;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(pin, link);
  endtask

  // Drop valid and let every pending report drain before any register write.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register transfer; valid is left high for back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Program all four registers. Bits above each field are random so the
  // block must mask them; an extra write to an unused index must be ignored.
  task automatic program_regs(input logic [DEB_W-1:0] deb,
                              input logic [GAP_W-1:0] gap,
                              input logic [HB_W-1:0]  hb,
                              input logic             ah);
    logic [CFG_DATA_W-1:0] dat;
    logic [CFG_IDX_W-1:0]  stray;
    wait_idle();
    dat = $urandom(); dat[DEB_W-1:0] = deb;
    write_reg(REG_DEBOUNCE, dat);
    dat = $urandom(); dat[GAP_W-1:0] = gap;
    write_reg(REG_MIN_GAP, dat);
    stray = CFG_IDX_W'($urandom_range({CFG_IDX_W{1'b1}}, REG_ACTIVE_HIGH + 1));
    write_reg(stray, $urandom());
    dat = $urandom(); dat[HB_W-1:0] = hb;
    write_reg(REG_HEARTBEAT, dat);
    dat = $urandom(); dat[0] = ah;
    write_reg(REG_ACTIVE_HIGH, dat);
    cfg_ch.valid <= 1'b0;
  endtask

  // Pin held in runs so debounce and gap can actually expire; the short
  // single-tick runs act as glitches. Link flips now and then.
  task automatic run_random(input int unsigned n_items);
    logic        lvl;
    logic        link;
    int unsigned run_len;
    int unsigned sent;
    link = 1'($urandom_range(1, 0));
    sent = 0;
    while (sent < n_items) begin
      lvl     = 1'($urandom_range(1, 0));
      run_len = ($urandom_range(99) < 75) ? $urandom_range(12, 1) : 1;
      repeat (run_len) begin
        if (sent < n_items) begin
          if ($urandom_range(99) < 10) link = !link;
          send_tick(lvl, link);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Report sink: random ready, plus one long hold-off once traffic is going
  // so the block backs up and stalls the tick source. The hold-off starts
  // only while a tick is on offer, so the source keeps pushing into it.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned reports_seen;
    bit          held;
    hold_left    = 0;
    reports_seen = 0;
    held         = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_report(out_ch.kind, out_ch.beam_blocked, out_ch.blocked_total,
                        out_ch.last);
        reports_seen++;
      end
      if (!held && reports_seen >= 150 && in_ch.valid) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.pin_level <= 1'b0;
    in_ch.link_up   <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first tick loads state from the pin (active low, so
    // low pin means blocked), link rising edges, short pin blips well inside
    // the 50-tick debounce, and plain ticks that give only a status report.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);

    // Zero debounce, zero gap, zero heartbeat, active high: every change
    // confirms at once and every tick carries a heartbeat. A link edge on a
    // blocking tick gives the full four reports.
    program_regs('0, '0, '0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);

    // Small thresholds: debounce hold-off, same-state gap hold-off, and
    // heartbeat every few quiet ticks.
    program_regs(DEB_W'(3), GAP_W'(6), HB_W'(5), 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);

    // Random phases. Phase 0 pins every threshold at the top of its range (no
    // confirmation, no heartbeat); phase 3 runs with no idling on either side.
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: program_regs('1, '1, '1, 1'($urandom_range(1, 0)));
        3: program_regs('0, '0, HB_W'($urandom_range(8, 0)), 1'($urandom_range(1, 0)));
        default: program_regs(DEB_W'($urandom_range(6, 0)), GAP_W'($urandom_range(15, 0)),
                              HB_W'($urandom_range(40, 1)), 1'($urandom_range(1, 0)));
      endcase
      calm = (phase == 3);
      run_random(50);
    end
    calm = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
